// ----- sv/pfd_pkg.sv -----
package pfd_pkg;

    // Field and datapath widths
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int DT_W    = 24;
    localparam int FRAC_W  = 16;
    localparam int TFRAC_W = 24;
    localparam int LIM_W   = 31;
    localparam int ALPHA_W = 17;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIDE_W  = 82;
    localparam int TERM_W  = 62;
    localparam int QUOT_W  = 48;
    localparam int REM_W   = 32;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Filter weight of one (no filtering)
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // Smallest integral gain that enables the windup clamp is GI_THRESH + 1
    localparam logic signed [VAL_W-1:0] GI_THRESH = VAL_W'((2 ** FRAC_W) / 10000);

    // Saturation bound of the integral product term, 2^60
    localparam logic signed [PROD_W-1:0] TERM_LIM = PROD_W'(64'h1000_0000_0000_0000);

    // Divider step counts: windup bound and raw derivative
    localparam logic [CNT_W-1:0] ITER_BOUND = 6'd48;
    localparam logic [CNT_W-1:0] ITER_RAW   = 6'd32;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_DRIVE_LIM,
        REG_WINDUP_LIM,
        REG_ALPHA,
        REG_ENABLE
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_E,
        ST_ACC,
        ST_DIVB,
        ST_CLAMP,
        ST_ILO,
        ST_IHI,
        ST_IACC,
        ST_ISAT,
        ST_DIVR,
        ST_RAW,
        ST_F1,
        ST_F2,
        ST_FACC,
        ST_FILT,
        ST_MULD,
        ST_DTERM,
        ST_DONE
    } state_t;

    // Sequencer to datapath control
    typedef struct packed {
        state_t state;
        logic   accept;
        logic   div_start;
        logic   load_out;
    } seq_ctl_t;

endpackage

// ----- sv/pid_filtered_derivative_unit.sv -----
// PID channel with windup clamp and low-pass filtered derivative.
// Running requests use the shared radix-2 divider twice and wait on it
// (48 steps for the windup bound, 32 for the derivative).
// Disabled loop or zero time step: drive of zero, going straight to the final step.
// One request at a time: in_stall stays high until the drive is loaded and idle returns.
// rst_n is asynchronous: gains and limits clear, alpha=1.0, enable=1, state zero.
module pid_filtered_derivative_unit
    import pfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [VAL_W-1:0]  target_value,
    input  logic signed [VAL_W-1:0]  measured_value,
    input  logic [DT_W-1:0]          time_step,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [VAL_W-1:0]  drive
);

    localparam logic signed [PROD_W-1:0] FILT_MAX = PROD_W'(32'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] FILT_MIN = -PROD_W'(64'sh8000_0000);

    // Configuration
    logic signed [VAL_W-1:0]   gain_p_reg, gain_p_next;
    logic signed [VAL_W-1:0]   gain_i_reg, gain_i_next;
    logic signed [VAL_W-1:0]   gain_d_reg, gain_d_next;
    logic [LIM_W-1:0]          drive_lim_reg, drive_lim_next;
    logic [LIM_W-1:0]          windup_lim_reg, windup_lim_next;
    logic [ALPHA_W-1:0]        alpha_reg, alpha_next;
    logic                      enable_reg, enable_next;

    // Loop state
    logic signed [ACC_W-1:0]   integ_reg, integ_next;
    logic signed [VAL_W-1:0]   last_err_reg, last_err_next;
    logic signed [VAL_W-1:0]   last_der_reg, last_der_next;

    // Working registers
    logic signed [VAL_W-1:0]   err_reg, err_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic                      skip_reg, skip_next;
    logic signed [ACC_W-1:0]   p_reg, p_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [TERM_W-1:0]  i_reg, i_next;
    logic signed [WIDE_W-1:0]  wide_reg, wide_next;
    logic signed [VAL_W-1:0]   raw_reg, raw_next;
    logic signed [VAL_W-1:0]   filt_reg, filt_next;
    logic signed [ACC_W-1:0]   d_reg, d_next;

    // Output stage
    logic                      out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0]   drive_reg, drive_next;

    seq_ctl_t                  ctl;
    logic                      cfg_wr;
    reg_idx_t                  cfg_idx;
    logic                      skip_in;
    logic                      out_free;
    logic signed [VAL_W:0]     err_wide;
    logic signed [VAL_W-1:0]   err_sat;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_busy;
    logic [QUOT_W-1:0]         quot;
    logic [REM_W-1:0]          div_rem_init;
    logic [QUOT_W-1:0]         div_dividend;
    logic [REM_W-1:0]          div_divisor;
    logic [CNT_W-1:0]          div_iters;
    logic                      gi_big;
    logic signed [ACC_W-1:0]   bound;
    logic signed [VAL_W:0]     diff;
    logic [VAL_W-1:0]          diff_mag;
    logic                      raw_ovf;
    logic [VAL_W-1:0]          fu;
    logic [ALPHA_W-1:0]        alpha_eff;
    logic [ALPHA_W-1:0]        alpha_rest;
    logic signed [PROD_W-1:0]  wq;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [VAL_W-1:0]   edt;
    logic signed [63:0]        pid_sum;
    logic signed [63:0]        lim_pos;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = reg_idx_t'(paddr[4:2]);
    assign in_stall = (ctl.state != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign skip_in  = !enable_reg || (time_step == '0);

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_P:     prdata = gain_p_reg;
            REG_GAIN_I:     prdata = gain_i_reg;
            REG_GAIN_D:     prdata = gain_d_reg;
            REG_DRIVE_LIM:  prdata = {1'b0, drive_lim_reg};
            REG_WINDUP_LIM: prdata = {1'b0, windup_lim_reg};
            REG_ALPHA:      prdata = {15'b0, alpha_reg};
            REG_ENABLE:     prdata = {31'b0, enable_reg};
            default:        prdata = '0;
        endcase
    end

    // Sequencer
    pfd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .skip     (skip_in),
        .div_busy (div_busy),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // Error, saturated to the value width
    assign err_wide = VAL_W'(1) == 0 ? '0 :
                      (VAL_W+1)'(target_value) - (VAL_W+1)'(measured_value);
    always_comb
    begin
        if (err_wide[VAL_W] != err_wide[VAL_W-1])
            err_sat = err_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}};
        else
            err_sat = err_wide[VAL_W-1:0];
    end

    // Derivative difference and filter weights
    assign diff       = (VAL_W+1)'(err_reg) - (VAL_W+1)'(last_err_reg);
    assign diff_mag   = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    assign raw_ovf    = (diff_mag >= {dt_reg, 8'b0});
    assign fu         = quot[VAL_W-1:0];
    assign alpha_eff  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_rest = ALPHA_ONE - alpha_eff;
    assign gi_big     = (gain_i_reg > GI_THRESH);
    assign bound      = $signed(quot);
    assign wq         = wide_reg[WIDE_W-1:FRAC_W];
    assign edt        = prod[TFRAC_W+VAL_W-1:TFRAC_W];
    assign acc_sum    = (ACC_W+1)'(integ_reg) + (ACC_W+1)'(edt);

    // Shared multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ctl.state)
            ST_MUL_P:
            begin
                op_a = MUL_W'(gain_p_reg);
                op_b = MUL_W'(err_reg);
            end
            ST_MUL_E:
            begin
                op_a = MUL_W'(err_reg);
                op_b = {9'b0, dt_reg};
            end
            ST_ILO:
            begin
                op_a = MUL_W'(gain_i_reg);
                op_b = {1'b0, acc_reg[31:0]};
            end
            ST_IHI:
            begin
                op_a = MUL_W'(gain_i_reg);
                op_b = MUL_W'($signed(acc_reg[ACC_W-1:32]));
            end
            ST_F1:
            begin
                op_a = {16'b0, alpha_eff};
                op_b = MUL_W'(raw_reg);
            end
            ST_F2:
            begin
                op_a = {16'b0, alpha_rest};
                op_b = MUL_W'(last_der_reg);
            end
            ST_MULD:
            begin
                op_a = MUL_W'(gain_d_reg);
                op_b = MUL_W'(filt_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    pfd_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Shared divider: windup bound when started from ACC, derivative otherwise
    always_comb
    begin
        if (ctl.state == ST_ACC)
        begin
            div_rem_init = '0;
            div_dividend = {1'b0, windup_lim_reg, 16'b0};
            div_divisor  = gain_i_reg;
            div_iters    = ITER_BOUND;
        end
        else
        begin
            div_rem_init = {8'b0, diff_mag[VAL_W-1:8]};
            div_dividend = {diff_mag[7:0], 40'b0};
            div_divisor  = {8'b0, dt_reg};
            div_iters    = ITER_RAW;
        end
    end

    pfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quot     (quot)
    );

    // Final sum and drive clamp
    assign pid_sum = 64'(p_reg) + 64'(i_reg) + 64'(d_reg);
    assign lim_pos = $signed({33'b0, drive_lim_reg});

    // Datapath steps
    always_comb
    begin
        err_next  = err_reg;
        dt_next   = dt_reg;
        skip_next = skip_reg;
        p_next    = p_reg;
        acc_next  = acc_reg;
        i_next    = i_reg;
        wide_next = wide_reg;
        raw_next  = raw_reg;
        filt_next = filt_reg;
        d_next    = d_reg;
        case (ctl.state)
            ST_IDLE:
            begin
                if (ctl.accept)
                begin
                    err_next  = err_sat;
                    dt_next   = time_step;
                    skip_next = skip_in;
                end
            end
            ST_MUL_E: p_next = prod[FRAC_W+ACC_W-1:FRAC_W];
            ST_ACC:
            begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                    acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                              : {1'b0, {(ACC_W-1){1'b1}}};
                else
                    acc_next = acc_sum[ACC_W-1:0];
            end
            ST_CLAMP:
            begin
                if (gi_big)
                begin
                    if (acc_reg > bound)
                        acc_next = bound;
                    else if (acc_reg < -bound)
                        acc_next = -bound;
                end
            end
            ST_IHI:  wide_next = WIDE_W'(prod);
            ST_IACC: wide_next = wide_reg + (WIDE_W'(prod) <<< 32);
            ST_ISAT:
            begin
                if (wq > TERM_LIM)
                    i_next = TERM_LIM[TERM_W-1:0];
                else if (wq < -TERM_LIM)
                    i_next = TERM_W'(-TERM_LIM);
                else
                    i_next = wq[TERM_W-1:0];
            end
            ST_RAW:
            begin
                if (!diff[VAL_W])
                    raw_next = (raw_ovf || fu[VAL_W-1]) ? {1'b0, {(VAL_W-1){1'b1}}}
                                                        : fu;
                else if (raw_ovf || (fu > {1'b1, {(VAL_W-1){1'b0}}}))
                    raw_next = {1'b1, {(VAL_W-1){1'b0}}};
                else
                    raw_next = -fu;
            end
            ST_F2:   wide_next = WIDE_W'(prod);
            ST_FACC: wide_next = wide_reg + WIDE_W'(prod);
            ST_FILT:
            begin
                if (wq > FILT_MAX)
                    filt_next = FILT_MAX[VAL_W-1:0];
                else if (wq < FILT_MIN)
                    filt_next = FILT_MIN[VAL_W-1:0];
                else
                    filt_next = wq[VAL_W-1:0];
            end
            ST_DTERM: d_next = prod[FRAC_W+ACC_W-1:FRAC_W];
            default:
            begin
                err_next = err_reg;
            end
        endcase
    end

    // Drive output stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
            if (skip_reg)
                drive_next = '0;
            else if (pid_sum > lim_pos)
                drive_next = lim_pos[VAL_W-1:0];
            else if (pid_sum < -lim_pos)
                drive_next = VAL_W'(-lim_pos);
            else
                drive_next = pid_sum[VAL_W-1:0];
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration writes and loop state update
    always_comb
    begin
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        drive_lim_next  = drive_lim_reg;
        windup_lim_next = windup_lim_reg;
        alpha_next      = alpha_reg;
        enable_next     = enable_reg;
        integ_next      = integ_reg;
        last_err_next   = last_err_reg;
        last_der_next   = last_der_reg;
        if (ctl.load_out && !skip_reg)
        begin
            integ_next    = acc_reg;
            last_err_next = err_reg;
            last_der_next = filt_reg;
        end
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_P:     gain_p_next = pwdata;
                REG_GAIN_I:     gain_i_next = pwdata;
                REG_GAIN_D:     gain_d_next = pwdata;
                REG_DRIVE_LIM:  drive_lim_next = pwdata[LIM_W-1:0];
                REG_WINDUP_LIM: windup_lim_next = pwdata[LIM_W-1:0];
                REG_ALPHA:      alpha_next = pwdata[ALPHA_W-1:0];
                REG_ENABLE:
                begin
                    enable_next = pwdata[0];
                    if (!pwdata[0])
                    begin
                        integ_next    = '0;
                        last_err_next = '0;
                        last_der_next = '0;
                    end
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            drive_lim_reg  <= '0;
            windup_lim_reg <= '0;
            alpha_reg      <= ALPHA_ONE;
            enable_reg     <= 1'b1;
            integ_reg      <= '0;
            last_err_reg   <= '0;
            last_der_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            drive_lim_reg  <= drive_lim_next;
            windup_lim_reg <= windup_lim_next;
            alpha_reg      <= alpha_next;
            enable_reg     <= enable_next;
            integ_reg      <= integ_next;
            last_err_reg   <= last_err_next;
            last_der_reg   <= last_der_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        dt_reg    <= dt_next;
        skip_reg  <= skip_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        i_reg     <= i_next;
        wide_reg  <= wide_next;
        raw_reg   <= raw_next;
        filt_reg  <= filt_next;
        d_reg     <= d_next;
        drive_reg <= drive_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // A drive only appears out of the final step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.state == ST_DONE))
        else $error("drive raised outside final step");

    // Skipped requests yield a zero drive
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_out && skip_reg) |=> (drive_reg == '0))
        else $error("skipped request gave nonzero drive");

    // After the windup clamp the integral sits inside the bound
    a_windup_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.state == ST_ILO && gi_big) |-> (acc_reg <= bound && acc_reg >= -bound))
        else $error("integral outside windup bound");

endmodule

// ----- sv/pfd_mul.sv -----
module pfd_mul
    import pfd_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Signed 33x33 product, registered
    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/pfd_div.sv -----
module pfd_div
    import pfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [REM_W-1:0]  rem_init,
    input  logic [QUOT_W-1:0] dividend,
    input  logic [REM_W-1:0]  divisor,
    input  logic [CNT_W-1:0]  iters,
    output logic              busy,
    output logic [QUOT_W-1:0] quot
);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0]  dvs_reg, dvs_next;
    logic [REM_W:0]    shifted;
    logic [REM_W:0]    trial;
    logic              fits;

    // One restoring step: dividend bits leave at the top, quotient bits enter below
    assign shifted = {rem_reg, dvd_reg[QUOT_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = rem_init;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
            rem_next  = fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
            dvd_next  = {dvd_reg[QUOT_W-2:0], fits};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign quot = dvd_reg;

    // A new request never lands on a running divide
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// ----- sv/pfd_seq.sv -----
module pfd_seq
    import pfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     skip,
    input  logic     div_busy,
    input  logic     out_free,
    output seq_ctl_t ctl
);

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = skip ? ST_DONE : ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_E;
            ST_MUL_E: state_next = ST_ACC;
            ST_ACC:   state_next = ST_DIVB;
            ST_DIVB:  if (!div_busy) state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_ILO;
            ST_ILO:   state_next = ST_IHI;
            ST_IHI:   state_next = ST_IACC;
            ST_IACC:  state_next = ST_ISAT;
            ST_ISAT:  state_next = ST_DIVR;
            ST_DIVR:  if (!div_busy) state_next = ST_RAW;
            ST_RAW:   state_next = ST_F1;
            ST_F1:    state_next = ST_F2;
            ST_F2:    state_next = ST_FACC;
            ST_FACC:  state_next = ST_FILT;
            ST_FILT:  state_next = ST_MULD;
            ST_MULD:  state_next = ST_DTERM;
            ST_DTERM: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.state     = state_reg;
        ctl.accept    = (state_reg == ST_IDLE) && in_valid;
        ctl.div_start = (state_reg == ST_ACC) || (state_reg == ST_ISAT);
        ctl.load_out  = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // An accepted request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> (state_reg == ST_MUL_P || state_reg == ST_DONE))
        else $error("accepted request did not start");

endmodule

// ----- verif/pid_drive_checker.sv -----
`timescale 1ns / 1ps

module pid_drive_checker
    import pfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [VAL_W-1:0] target_value,
    input  logic signed [VAL_W-1:0] measured_value,
    input  logic [DT_W-1:0]         time_step,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [VAL_W-1:0] drive,
    output int                      fail_count,
    output int                      pending
);

    typedef logic signed [127:0] wide_t;

    // Shadow of the register file
    wide_t        kp, ki, kd, drive_lim, windup_lim;
    logic [16:0]  alpha_reg;
    logic         loop_on;

    // Shadow of the controller state
    wide_t        integ, prev_err, prev_deriv;

    logic [VAL_W-1:0] drive_q[$];

    function automatic wide_t sat_to(wide_t x, int w);
        wide_t hi;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    // floor(a*b / 2^sh), clamped to +/- 2^60
    function automatic wide_t scaled_product(wide_t a, wide_t b, int sh);
        wide_t p, lim;
        p = (a * b) >>> sh;
        lim = wide_t'(1) <<< 60;
        if (p > lim) return lim;
        if (p < -lim) return -lim;
        return p;
    endfunction

    // Drive for one request; advances the shadow state
    function automatic wide_t pid_drive(wide_t tgt, wide_t meas, wide_t dt);
        wide_t err, p_t, i_t, d_t, acc, bound, diff, mag, fu, raw, a, filt, sum;
        if (!loop_on || dt == 0) return 0;
        err = sat_to(tgt - meas, VAL_W);
        p_t = scaled_product(kp, err, FRAC_W);
        acc = sat_to(integ + scaled_product(err, dt, TFRAC_W), ACC_W);
        if (ki > wide_t'(GI_THRESH)) begin
            bound = (windup_lim <<< FRAC_W) / ki;
            if (acc > bound) acc = bound;
            if (acc < -bound) acc = -bound;
        end
        integ = acc;
        i_t = scaled_product(ki, acc, FRAC_W);
        diff = err - prev_err;
        mag = (diff < 0) ? -diff : diff;
        fu = (mag <<< TFRAC_W) / dt;
        raw = sat_to((diff < 0) ? -fu : fu, VAL_W);
        a = (alpha_reg > 17'd65536) ? wide_t'(65536) : wide_t'(alpha_reg);
        filt = sat_to((a * raw + (65536 - a) * prev_deriv) >>> 16, VAL_W);
        d_t = scaled_product(kd, filt, FRAC_W);
        prev_err = err;
        prev_deriv = filt;
        sum = p_t + i_t + d_t;
        if (sum > drive_lim) sum = drive_lim;
        if (sum < -drive_lim) sum = -drive_lim;
        return sum;
    endfunction

    assign pending = drive_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        wide_t res;
        if (!rst_n)
        begin
            kp = 0; ki = 0; kd = 0; drive_lim = 0; windup_lim = 0;
            alpha_reg = ALPHA_ONE;
            loop_on = 1'b1;
            integ = 0; prev_err = 0; prev_deriv = 0;
            fail_count = 0;
            drive_q.delete();
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_GAIN_P:     kp = wide_t'($signed(pwdata));
                    REG_GAIN_I:     ki = wide_t'($signed(pwdata));
                    REG_GAIN_D:     kd = wide_t'($signed(pwdata));
                    REG_DRIVE_LIM:  drive_lim = wide_t'(pwdata[30:0]);
                    REG_WINDUP_LIM: windup_lim = wide_t'(pwdata[30:0]);
                    REG_ALPHA:      alpha_reg = pwdata[16:0];
                    REG_ENABLE:
                    begin
                        loop_on = pwdata[0];
                        if (!pwdata[0])
                        begin
                            integ = 0; prev_err = 0; prev_deriv = 0;
                        end
                    end
                    default: ;
                endcase
            end
            // accepted request
            if (in_valid && !in_stall)
            begin
                res = pid_drive(wide_t'(target_value), wide_t'(measured_value),
                                wide_t'(time_step));
                drive_q.push_back(res[VAL_W-1:0]);
            end
            // accepted drive
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected drive %0d", drive);
                end
                else
                begin
                    res = wide_t'($signed(drive_q.pop_front()));
                    if (res[VAL_W-1:0] !== drive)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("drive mismatch: exp %0d got %0d",
                                     $signed(res[VAL_W-1:0]), drive);
                    end
                end
            end
        end
    end

endmodule

// ----- verif/pid_filtered_derivative_unit_test.sv -----
`timescale 1ns / 1ps

module pid_filtered_derivative_unit_test;
    import pfd_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 130;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [VAL_W-1:0] target_value = '0, measured_value = '0;
    logic [DT_W-1:0]         time_step = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] drive;

    int fail_count, pending;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int quiet_cycles = 0;
    logic signed [31:0] plant_target = 0;

    pid_filtered_derivative_unit DUT (.*);

    pid_drive_checker checker_i (.*);

    always #1 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all drives, then let the pipeline settle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_req(input logic [31:0] tgt, input logic [31:0] meas,
                            input logic [23:0] dt);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        target_value <= tgt; measured_value <= meas; time_step <= dt;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            3: return 32'd0;
            default: return $urandom_range(0, 32'h0002_0000) - 32'h0000_8000;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'd0;
            2: return $urandom();
            default: return $urandom_range(1, 32'h0100_0000);
        endcase
    endfunction

    task automatic random_setup(input bit run_loop);
        reg_write(REG_GAIN_P, pick_gain());
        reg_write(REG_GAIN_I, pick_gain());
        reg_write(REG_GAIN_D, pick_gain());
        reg_write(REG_DRIVE_LIM, pick_limit());
        reg_write(REG_WINDUP_LIM, pick_limit());
        case ($urandom_range(3))
            0: reg_write(REG_ALPHA, 32'd65536);
            1: reg_write(REG_ALPHA, $urandom_range(0, 32'h1FFFF));
            default: reg_write(REG_ALPHA, $urandom_range(0, 65536));
        endcase
        reg_write(REG_ENABLE, 32'd0);
        if (run_loop) reg_write(REG_ENABLE, 32'd1);
    endtask

    // Mostly a slowly moving plant; some raw noise and zero steps
    task automatic random_batch(input int n);
        logic [31:0] meas;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(19) == 0)
                    plant_target = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                meas = plant_target + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
                send_req(plant_target, meas, $urandom_range(1, 32'h0004_0000));
            end
            else if ($urandom_range(9) == 0)
                send_req($urandom(), $urandom(), 24'd0);
            else
                send_req($urandom(), $urandom(), $urandom_range(1, 24'hFFFFFF));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: moderate gains
        reg_write(REG_GAIN_P, 32'h0001_0000);
        reg_write(REG_GAIN_I, 32'h0000_8000);
        reg_write(REG_GAIN_D, 32'h0000_199A);
        reg_write(REG_DRIVE_LIM, 32'h7FFF_FFFF);
        reg_write(REG_WINDUP_LIM, 32'h0064_0000);
        reg_write(REG_ALPHA, 32'h0000_8000);
        reg_write(REG_ENABLE, 32'd1);
        send_req(32'h0001_0000, 32'd0, 24'd0);
        send_req(32'h0001_0000, 32'd0, 24'd1);
        send_req(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
        send_req(32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
        send_req(32'hFFFF_FFFF, 32'h0000_0001, 24'hAAAAAA);
        send_req(32'h5555_5555, 32'hAAAA_AAAA, 24'h555555);
        send_req(32'd0, 32'd0, 24'hFFFFFF);
        wait_quiet();

        // small and negative integral gain skip the clamp; alpha above one
        reg_write(REG_GAIN_I, 32'd6);
        reg_write(REG_ALPHA, 32'h0001_FFFF);
        send_req(32'h0100_0000, 32'd0, 24'h100000);
        send_req(32'h0100_0000, 32'd0, 24'h100000);
        wait_quiet();
        reg_write(REG_GAIN_I, 32'hFFFF_FFFB);
        reg_write(REG_GAIN_P, 32'h7FFF_FFFF);
        reg_write(REG_GAIN_D, 32'h8000_0000);
        send_req(32'h7FFF_FFFF, 32'h8000_0000, 24'd3);
        wait_quiet();

        // zero drive limit; out-of-map write; disable clears state
        reg_write(REG_DRIVE_LIM, 32'd0);
        send_req(32'h0040_0000, 32'd0, 24'd100);
        wait_quiet();
        reg_write(reg_idx_t'(3'd7), 32'hFFFF_FFFF);
        reg_write(REG_DRIVE_LIM, 32'h7FFF_FFFF);
        reg_write(REG_ENABLE, 32'd0);
        send_req(32'h0040_0000, 32'd0, 24'd100);
        wait_quiet();
        reg_write(REG_ENABLE, 32'd0);
        reg_write(REG_ENABLE, 32'd1);
        reg_write(REG_GAIN_I, 32'h0001_0000);
        send_req(32'h0040_0000, 32'd0, 24'd100);
        send_req(32'h0040_0000, 32'h0010_0000, 24'd50);
        wait_quiet();

        // random phases across idle and stall mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            random_setup(ph != 5);
            random_batch(210);
            wait_quiet();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
